// ----- design/wcpf_pkg.sv -----
// Shared types, constants and the suppression test of the window count peak finder.
package wcpf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 256;
   localparam int MAX_HEIGHT_DEF = 1048576;

   localparam int COUNT_W     = 17;
   localparam int COORD_W     = 25;
   localparam int POS_W       = 22;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 25;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_USER_W  = 2;
   localparam int OUT_DEPTH   = 16;
   localparam int PIPE_STAGES = 4;

   localparam logic [CSR_IDX_W-1:0] REG_REGION_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_COUNT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z      = 3'd5;

   // per-request control carried down the pipeline
   typedef struct packed {
      logic       z_first;
      logic       z_ge_w;
      logic       x_first;
      logic       x_ge_w;
      logic       cnt;
      logic [3:0] judge;
      logic       a_ge1;
      logic       a_ge2;
      logic       b_ge1;
      logic       b_ge2;
      logic       scan_end;
      logic       too_small;
   } ctl_type;

   // 3x3 count window, [row][col], row 2 / col 2 newest
   typedef logic [2:0][2:0][COUNT_W-1:0] win_type;

   typedef struct packed {
      logic               too_small;
      logic               end_marker;
      logic               last;
      logic [COORD_W-1:0] cz;
      logic [COORD_W-1:0] cx;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // true if the square at (cr,cc) reaches minc and no valid neighbour beats it
   function automatic logic square_survives(input win_type win, input logic [2:0] row_ok,
                                            input logic [2:0] col_ok, input int cr,
                                            input int cc, input logic [COUNT_W-1:0] minc);
      logic               keep;
      logic               earlier;
      logic [COUNT_W-1:0] cen;
      logic [COUNT_W-1:0] other;
      int                 r;
      int                 c;
      cen  = win[cr][cc];
      keep = (cen >= minc);
      for (int dz = -1; dz <= 1; dz++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            r = cr + dz;
            c = cc + dx;
            if (!(dz == 0 && dx == 0) && r >= 0 && r <= 2 && c >= 0 && c <= 2) begin
               if (row_ok[r] && col_ok[c]) begin
                  other   = win[r][c];
                  earlier = (dz < 0) || (dz == 0 && dx < 0);
                  if (other > cen || (other == cen && earlier)) begin
                     keep = 1'b0;
                  end
               end
            end
         end
      end
      return keep;
   endfunction

endpackage

// ----- design/wcpf_box.sv -----
// Box sum stage: flag history, column window sums and the running square count.
module wcpf_box #(
   parameter int MAX_WIDTH  = wcpf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = wcpf_pkg::MAX_WINDOW_DEF,
   parameter int MAX_HEIGHT = wcpf_pkg::MAX_HEIGHT_DEF,
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int ZW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_flag,
   input  logic [XW-1:0]                in_x,
   input  logic [XW-1:0]                in_x_sub,
   input  logic [SW-1:0]                in_slot,
   input  logic [SW-1:0]                in_oldslot,
   input  logic [XW-1:0]                in_a,
   input  logic [ZW-1:0]                in_b,
   input  wcpf_pkg::ctl_type            in_ctl,
   output logic                         out_valid,
   output wcpf_pkg::ctl_type            out_ctl,
   output logic [XW-1:0]                out_a,
   output logic [ZW-1:0]                out_b,
   output logic [wcpf_pkg::COUNT_W-1:0] out_count
);
   import wcpf_pkg::*;

   localparam int CSW = $clog2(MAX_WINDOW + 1) + 1;
   localparam int HD  = MAX_WINDOW * (2 ** XW);
   localparam int CD  = 2 ** XW;

   logic           hist_mem [0:HD-1];
   logic [CSW-1:0] col_mem  [0:CD-1];

   logic           hist_rd_ff;
   logic [CSW-1:0] col_rd_a_ff;
   logic [CSW-1:0] col_rd_b_ff;

   logic           s1_valid_ff;
   logic           s1_flag_ff;
   logic [XW-1:0]  s1_x_ff;
   logic [XW-1:0]  s1_a_ff;
   logic [ZW-1:0]  s1_b_ff;
   ctl_type        s1_ctl_ff;
   logic           byp_a_ff;
   logic           byp_b_ff;
   logic           byp_a_in;
   logic           byp_b_in;

   logic [CSW-1:0] last_col_ff;
   logic [CSW-1:0] col_prev;
   logic [CSW-1:0] col_sub;
   logic [CSW-1:0] col_new;
   logic [COUNT_W-1:0] sum_new;

   logic               out_valid_ff;
   ctl_type            out_ctl_ff;
   logic [XW-1:0]      out_a_ff;
   logic [ZW-1:0]      out_b_ff;
   logic [COUNT_W-1:0] sum_ff;

   // the request in S1 writes its column sum after this read; forward it
   assign byp_a_in = s1_valid_ff && (s1_x_ff == in_x);
   assign byp_b_in = s1_valid_ff && (s1_x_ff == in_x_sub);

   always_ff @(posedge clock) begin
      if (in_valid) begin
         hist_mem[{in_slot, in_x}] <= in_flag;
         hist_rd_ff  <= hist_mem[{in_oldslot, in_x}];
         col_rd_a_ff <= col_mem[in_x];
         col_rd_b_ff <= col_mem[in_x_sub];
      end
      if (s1_valid_ff) begin
         col_mem[s1_x_ff] <= col_new;
      end
   end

   always_comb begin
      col_prev = byp_a_ff ? last_col_ff : col_rd_a_ff;
      col_sub  = byp_b_ff ? last_col_ff : col_rd_b_ff;
      col_new  = (s1_ctl_ff.z_first ? '0 : col_prev) + CSW'(s1_flag_ff)
               - (s1_ctl_ff.z_ge_w ? CSW'(hist_rd_ff) : '0);
      sum_new  = (s1_ctl_ff.x_first ? '0 : sum_ff) + COUNT_W'(col_new)
               - (s1_ctl_ff.x_ge_w ? COUNT_W'(col_sub) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
      if (in_valid) begin
         s1_flag_ff <= in_flag;
         s1_x_ff    <= in_x;
         s1_a_ff    <= in_a;
         s1_b_ff    <= in_b;
         s1_ctl_ff  <= in_ctl;
         byp_a_ff   <= byp_a_in;
         byp_b_ff   <= byp_b_in;
      end
      if (s1_valid_ff) begin
         last_col_ff <= col_new;
         sum_ff      <= sum_new;
         out_ctl_ff  <= s1_ctl_ff;
         out_a_ff    <= s1_a_ff;
         out_b_ff    <= s1_b_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_ctl   = out_ctl_ff;
   assign out_a     = out_a_ff;
   assign out_b     = out_b_ff;
   assign out_count = sum_ff;

endmodule

// ----- design/wcpf_nms.sv -----
// Suppression stage: count line buffer, 3x3 count window and neighbour test.
module wcpf_nms #(
   parameter int MAX_WIDTH  = wcpf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wcpf_pkg::MAX_HEIGHT_DEF,
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int ZW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  wcpf_pkg::ctl_type            in_ctl,
   input  logic [XW-1:0]                in_a,
   input  logic [ZW-1:0]                in_b,
   input  logic [wcpf_pkg::COUNT_W-1:0] in_count,
   input  logic [wcpf_pkg::COUNT_W-1:0] minc,
   input  logic [wcpf_pkg::COORD_W-1:0] origin_x,
   input  logic [wcpf_pkg::COORD_W-1:0] origin_z,
   output logic                         out_valid,
   output logic                         out_sq,
   output wcpf_pkg::rsp_type            out_sq_item,
   output logic                         out_end,
   output wcpf_pkg::rsp_type            out_end_item
);
   import wcpf_pkg::*;

   localparam int LD = 2 ** XW;

   logic [2*COUNT_W-1:0] lb_mem [0:LD-1];
   logic [2*COUNT_W-1:0] lb_rd_ff;
   logic [2*COUNT_W-1:0] last_wr_ff;
   logic [2*COUNT_W-1:0] lb_old;
   logic [2*COUNT_W-1:0] lb_new;

   logic               s3_valid_ff;
   ctl_type            s3_ctl_ff;
   logic [XW-1:0]      s3_a_ff;
   logic [ZW-1:0]      s3_b_ff;
   logic [COUNT_W-1:0] s3_count_ff;
   logic               s3_byp_ff;
   logic               byp_in;

   logic               s4_valid_ff;
   ctl_type            s4_ctl_ff;
   logic [XW-1:0]      s4_a_ff;
   logic [ZW-1:0]      s4_b_ff;

   win_type win_ff;
   win_type win_in;

   logic [2:0] row_ok;
   logic [2:0] col_ok;
   logic [3:0] ok;
   logic       sel_prev_col;
   logic       sel_prev_row;
   logic [XW-1:0] col_idx;
   logic [ZW-1:0] row_idx;
   logic [COUNT_W-1:0] sq_count;

   // the previous count in S3 writes the same column after this read
   assign byp_in = s3_valid_ff && s3_ctl_ff.cnt && (s3_a_ff == in_a);

   assign lb_old = s3_byp_ff ? last_wr_ff : lb_rd_ff;
   assign lb_new = {s3_count_ff, lb_old[2*COUNT_W-1:COUNT_W]};

   always_ff @(posedge clock) begin
      if (in_valid && in_ctl.cnt) begin
         lb_rd_ff <= lb_mem[in_a];
      end
      if (s3_valid_ff && s3_ctl_ff.cnt) begin
         lb_mem[s3_a_ff] <= lb_new;
      end
   end

   // shift in the new column: rows b-2, b-1, b
   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = lb_old[COUNT_W-1:0];
      win_in[1][2] = lb_old[2*COUNT_W-1:COUNT_W];
      win_in[2][2] = s3_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
      if (in_valid) begin
         s3_ctl_ff   <= in_ctl;
         s3_a_ff     <= in_a;
         s3_b_ff     <= in_b;
         s3_count_ff <= in_count;
         s3_byp_ff   <= byp_in;
      end
      if (s3_valid_ff) begin
         s4_ctl_ff <= s3_ctl_ff;
         s4_a_ff   <= s3_a_ff;
         s4_b_ff   <= s3_b_ff;
         if (s3_ctl_ff.cnt) begin
            win_ff     <= win_in;
            last_wr_ff <= lb_new;
         end
      end
   end

   assign row_ok = {1'b1, s4_ctl_ff.b_ge1, s4_ctl_ff.b_ge2};
   assign col_ok = {1'b1, s4_ctl_ff.a_ge1, s4_ctl_ff.a_ge2};

   always_comb begin
      ok[0] = s4_ctl_ff.judge[0] && square_survives(win_ff, row_ok, col_ok, 1, 1, minc);
      ok[1] = s4_ctl_ff.judge[1] && square_survives(win_ff, row_ok, col_ok, 1, 2, minc);
      ok[2] = s4_ctl_ff.judge[2] && square_survives(win_ff, row_ok, col_ok, 2, 1, minc);
      ok[3] = s4_ctl_ff.judge[3] && square_survives(win_ff, row_ok, col_ok, 2, 2, minc);
      priority if (ok[0]) begin
         sel_prev_col = 1'b1;
         sel_prev_row = 1'b1;
         sq_count     = win_ff[1][1];
      end else if (ok[1]) begin
         sel_prev_col = 1'b0;
         sel_prev_row = 1'b1;
         sq_count     = win_ff[1][2];
      end else if (ok[2]) begin
         sel_prev_col = 1'b1;
         sel_prev_row = 1'b0;
         sq_count     = win_ff[2][1];
      end else begin
         sel_prev_col = 1'b0;
         sel_prev_row = 1'b0;
         sq_count     = win_ff[2][2];
      end
      col_idx = sel_prev_col ? (s4_a_ff - XW'(1)) : s4_a_ff;
      row_idx = sel_prev_row ? (s4_b_ff - ZW'(1)) : s4_b_ff;
   end

   assign out_valid = s4_valid_ff;
   assign out_sq    = s4_valid_ff && (ok != 4'b0000);
   assign out_end   = s4_valid_ff && s4_ctl_ff.scan_end;

   always_comb begin
      out_sq_item.count      = sq_count;
      out_sq_item.cx         = origin_x + COORD_W'(col_idx);
      out_sq_item.cz         = origin_z + COORD_W'(row_idx);
      out_sq_item.end_marker = 1'b0;
      out_sq_item.too_small  = 1'b0;
      out_sq_item.last       = !s4_ctl_ff.scan_end;
      out_end_item.count      = '0;
      out_end_item.cx         = '0;
      out_end_item.cz         = '0;
      out_end_item.end_marker = 1'b1;
      out_end_item.too_small  = s4_ctl_ff.too_small;
      out_end_item.last       = 1'b1;
   end

endmodule

// ----- design/wcpf_out_fifo.sv -----
// Result buffer: takes up to two results per cycle, hands out one while out_ready is high.
module wcpf_out_fifo #(
   parameter int DEPTH = wcpf_pkg::OUT_DEPTH,
   localparam int PW = $clog2(DEPTH),
   localparam int LW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push0,
   input  wcpf_pkg::rsp_type data0,
   input  logic              push1,
   input  wcpf_pkg::rsp_type data1,
   output logic              out_valid,
   input  logic              out_ready,
   output wcpf_pkg::rsp_type out_data,
   output logic [LW-1:0]     level
);
   import wcpf_pkg::*;

   rsp_type       mem_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [LW-1:0] level_ff;
   logic [PW-1:0] wr1_ptr;
   logic          pop;

   assign pop     = out_ready && (level_ff != '0);
   assign wr1_ptr = push0 ? (wr_ptr_ff + PW'(1)) : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         mem_ff[wr1_ptr] <= data1;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(push0) + PW'(push1);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         level_ff  <= level_ff + LW'(push0) + LW'(push1) - LW'(pop);
      end
   end

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

// ----- design/window_count_peak_finder.sv -----
// Pipeline: box stage S1, box output register, suppression stages S3 and S4, then the result buffer.
// Throughput: one request per cycle; box sums advance once per request, count line buffer
// and 3x3 window once per request that completes a square. Hold off requests while the
// 16-entry result buffer lacks room for two results per request in flight plus the new one.
// Reset restores the register defaults and restarts the scan; flag history and count
// line memories hold no reset value and are only used once written in the current scan.
module window_count_peak_finder #(
   parameter int MAX_WIDTH  = wcpf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = wcpf_pkg::MAX_WINDOW_DEF,
   parameter int MAX_HEIGHT = wcpf_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wcpf_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] cell_flag
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wcpf_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [16:0] peak_count,
                                                        // [41:17] corner_x, [66:42] corner_z
   output logic [wcpf_pkg::RSP_USER_W-1:0] rsp_tuser,   // [0] end_marker, [1] area_too_small
   output logic                            rsp_tlast,   // last_in_run
   input  logic                            csr_we,
   input  logic [wcpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcpf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wcpf_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ZW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int LW = $clog2(OUT_DEPTH + 1);
   localparam int FW = $clog2(PIPE_STAGES + 1);

   // configuration registers, raw bits as written
   logic [10:0]        cfg_width_ff;
   logic [20:0]        cfg_height_ff;
   logic [8:0]         cfg_window_ff;
   logic [COUNT_W-1:0] cfg_min_ff;
   logic [COORD_W-1:0] cfg_ox_ff;
   logic [COORD_W-1:0] cfg_oz_ff;
   logic [COUNT_W-1:0] minc_ff;
   logic [COUNT_W-1:0] minc_in;

   // scan position
   logic [XW-1:0] x_ff;
   logic [ZW-1:0] z_ff;
   logic [SW-1:0] slot_ff;

   logic [POS_W-1:0] wd;
   logic [POS_W-1:0] ht;
   logic [POS_W-1:0] we;
   logic [POS_W-1:0] wc;
   logic [POS_W-1:0] hc;
   logic [POS_W-1:0] xe;
   logic [POS_W-1:0] ze;
   logic [POS_W-1:0] ae;
   logic [POS_W-1:0] be;
   logic [POS_W-1:0] se;
   logic [WW-1:0]    w_n;
   logic [2*WW-1:0]  w_sq;

   logic          accept;
   logic          row_done;
   ctl_type       ctl;
   logic [SW-1:0] oldslot;
   logic [XW-1:0] x_sub;

   logic               box_valid;
   ctl_type            box_ctl;
   logic [XW-1:0]      box_a;
   logic [ZW-1:0]      box_b;
   logic [COUNT_W-1:0] box_count;

   logic    nms_valid;
   logic    nms_sq;
   logic    nms_end;
   rsp_type nms_sq_item;
   rsp_type nms_end_item;

   rsp_type       head;
   logic [LW-1:0] fifo_level;
   logic [FW-1:0] inflight_ff;
   logic [7:0]    credit_need;

   // effective settings: clamp the raw registers into their legal ranges
   always_comb begin
      wd = (cfg_width_ff == '0) ? POS_W'(1) :
           (POS_W'(cfg_width_ff) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(cfg_width_ff);
      ht = (cfg_height_ff == '0) ? POS_W'(1) :
           (POS_W'(cfg_height_ff) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT)
                                                        : POS_W'(cfg_height_ff);
      we = (cfg_window_ff == '0) ? POS_W'(1) :
           (POS_W'(cfg_window_ff) > POS_W'(MAX_WINDOW)) ? POS_W'(MAX_WINDOW)
                                                        : POS_W'(cfg_window_ff);
      w_n  = WW'(we);
      w_sq = (2*WW)'(w_n) * (2*WW)'(w_n);
      minc_in = (POS_W'(cfg_min_ff) < POS_W'(w_sq)) ? cfg_min_ff : COUNT_W'(w_sq);
      wc = wd - we + POS_W'(1);
      hc = ht - we + POS_W'(1);
   end

   // per-request decode from the current scan position
   always_comb begin
      xe = POS_W'(x_ff);
      ze = POS_W'(z_ff);
      se = POS_W'(slot_ff);
      ae = xe + POS_W'(1) - we;
      be = ze + POS_W'(1) - we;
      ctl.z_first  = (z_ff == '0);
      ctl.z_ge_w   = (ze >= we);
      ctl.x_first  = (x_ff == '0);
      ctl.x_ge_w   = (xe >= we);
      ctl.cnt      = (xe + POS_W'(1) >= we) && (ze + POS_W'(1) >= we);
      // candidates in output order: up-left, up, left, current square
      ctl.judge[0] = ctl.cnt && (be >= POS_W'(1)) && (ae >= POS_W'(1));
      ctl.judge[1] = ctl.cnt && (be >= POS_W'(1)) && (ae == wc - POS_W'(1));
      ctl.judge[2] = ctl.cnt && (be == hc - POS_W'(1)) && (ae >= POS_W'(1));
      ctl.judge[3] = ctl.cnt && (be == hc - POS_W'(1)) && (ae == wc - POS_W'(1));
      ctl.a_ge1    = (ae >= POS_W'(1));
      ctl.a_ge2    = (ae >= POS_W'(2));
      ctl.b_ge1    = (be >= POS_W'(1));
      ctl.b_ge2    = (be >= POS_W'(2));
      row_done     = (xe + POS_W'(1) == wd);
      ctl.scan_end = row_done && (ze + POS_W'(1) == ht);
      ctl.too_small = (wd < we) || (ht < we);
      // history row leaving the vertical window
      oldslot = (se >= we) ? SW'(se - we) : SW'(se + POS_W'(MAX_WINDOW) - we);
      x_sub   = XW'(xe - we);
   end

   // hold off requests unless the result buffer has room for every one in flight
   assign credit_need = 8'(fifo_level) + 8'({inflight_ff, 1'b0}) + 8'd2;
   assign req_tready  = (credit_need <= 8'(OUT_DEPTH));
   assign accept      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 11'd1024;
         cfg_height_ff <= 21'd1024;
         cfg_window_ff <= 9'd10;
         cfg_min_ff    <= 17'd15;
         cfg_ox_ff     <= '0;
         cfg_oz_ff     <= '0;
         minc_ff       <= 17'd15;
         x_ff          <= '0;
         z_ff          <= '0;
         slot_ff       <= '0;
         inflight_ff   <= '0;
      end else begin
         minc_ff     <= minc_in;
         inflight_ff <= inflight_ff + FW'(accept) - FW'(nms_valid);
         if (csr_we && (csr_index == REG_REGION_WIDTH  || csr_index == REG_REGION_HEIGHT ||
                        csr_index == REG_WINDOW_SIZE   || csr_index == REG_MIN_COUNT     ||
                        csr_index == REG_ORIGIN_X      || csr_index == REG_ORIGIN_Z)) begin
            // any register write restarts the scan
            x_ff    <= '0;
            z_ff    <= '0;
            slot_ff <= '0;
         end else if (accept) begin
            if (ctl.scan_end) begin
               x_ff    <= '0;
               z_ff    <= '0;
               slot_ff <= '0;
            end else if (row_done) begin
               x_ff    <= '0;
               z_ff    <= z_ff + ZW'(1);
               slot_ff <= (se == POS_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + SW'(1);
            end else begin
               x_ff <= x_ff + XW'(1);
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_REGION_WIDTH:  cfg_width_ff  <= csr_wdata[10:0];
               REG_REGION_HEIGHT: cfg_height_ff <= csr_wdata[20:0];
               REG_WINDOW_SIZE:   cfg_window_ff <= csr_wdata[8:0];
               REG_MIN_COUNT:     cfg_min_ff    <= csr_wdata[COUNT_W-1:0];
               REG_ORIGIN_X:      cfg_ox_ff     <= csr_wdata[COORD_W-1:0];
               REG_ORIGIN_Z:      cfg_oz_ff     <= csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // column and square sums
   wcpf_box #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_box (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_flag    (req_tdata[0]),
      .in_x       (x_ff),
      .in_x_sub   (x_sub),
      .in_slot    (slot_ff),
      .in_oldslot (oldslot),
      .in_a       (XW'(ae)),
      .in_b       (ZW'(be)),
      .in_ctl     (ctl),
      .out_valid  (box_valid),
      .out_ctl    (box_ctl),
      .out_a      (box_a),
      .out_b      (box_b),
      .out_count  (box_count)
   );

   // neighbor suppression and result formatting
   wcpf_nms #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_nms (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (box_valid),
      .in_ctl       (box_ctl),
      .in_a         (box_a),
      .in_b         (box_b),
      .in_count     (box_count),
      .minc         (minc_ff),
      .origin_x     (cfg_ox_ff),
      .origin_z     (cfg_oz_ff),
      .out_valid    (nms_valid),
      .out_sq       (nms_sq),
      .out_sq_item  (nms_sq_item),
      .out_end      (nms_end),
      .out_end_item (nms_end_item)
   );

   // square first, end marker after it
   wcpf_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (nms_sq),
      .data0     (nms_sq_item),
      .push1     (nms_end),
      .data1     (nms_end_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head),
      .level     (fifo_level)
   );

   assign rsp_tdata = {(RSP_DATA_W - COUNT_W - 2*COORD_W)'(0), head.cz, head.cx, head.count};
   assign rsp_tuser = {head.too_small, head.end_marker};
   assign rsp_tlast = head.last;

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_level <= LW'(OUT_DEPTH))
      else $error("result buffer overflow");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= FW'(PIPE_STAGES))
      else $error("too many requests in flight");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata[COUNT_W-1:0] == '0))
      else $error("end marker not last or carries a count");

   a_accept_tracked: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (inflight_ff != '0))
      else $error("accepted request not tracked");

endmodule

// ----- tb/window_count_peak_finder_tb.sv -----
// Self-checking testbench of the window count peak finder: flag stream in, peaks checked.
module window_count_peak_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcpf_pkg::*;

   localparam int MAXW   = 1024;
   localparam int MAXWIN = 256;
   localparam int MAXH   = 1048576;
   localparam int LIMIT  = 400000;

   // one expected peak or end marker
   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cz;
      logic               end_mark;
      logic               too_small;
      logic               last;
   } peak_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   window_count_peak_finder u_dut (.*);

   always #10 clock = ~clock;

   // register copy (raw bits) and scan state of the predictor
   logic [10:0]        width_reg;
   logic [20:0]        height_reg;
   logic [8:0]         win_reg;
   logic [16:0]        min_reg;
   logic [COORD_W-1:0] ox_reg;
   logic [COORD_W-1:0] oz_reg;
   bit                 flag_hist [MAXWIN*MAXW];
   int                 col_sum [MAXW];
   int                 count_rows [3][MAXW];
   int                 box_sum;
   int                 scan_x;
   int                 scan_z;

   peak_type pending_peaks [$];
   int       errors = 0;
   int       cycles = 0;
   bit       jitter_on = 1'b1;
   int       hold_cycles = 0;

   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic void restart_scan();
      scan_x  = 0;
      scan_z  = 0;
      box_sum = 0;
   endfunction

   // append one expectation at the tail
   function automatic void queue_peak(peak_type p);
      pending_peaks = {pending_peaks, p};
   endfunction

   // queue a peak for square (a,b) if it reaches minc and no neighbor beats it
   function automatic int judge_square(int a, int b, int wc, int hc, int minc);
      int       c;
      int       other;
      int       na;
      int       nb;
      bit       earlier;
      peak_type p;
      c = count_rows[b % 3][a];
      if (c < minc) return 0;
      for (int dz = -1; dz <= 1; dz++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            na = a + dx;
            nb = b + dz;
            if ((dx != 0 || dz != 0) && na >= 0 && nb >= 0 && na < wc && nb < hc) begin
               other   = count_rows[nb % 3][na];
               earlier = (dz < 0) || (dz == 0 && dx < 0);
               if (other > c || (other == c && earlier)) return 0;
            end
         end
      end
      p.count     = c[COUNT_W-1:0];
      p.cx        = ox_reg + a[COORD_W-1:0];
      p.cz        = oz_reg + b[COORD_W-1:0];
      p.end_mark  = 1'b0;
      p.too_small = 1'b0;
      p.last      = 1'b0;
      queue_peak(p);
      return 1;
   endfunction

   // advance the predicted scan by one flag and queue the results it causes
   function automatic void predict_peaks(bit flag);
      int       wd;
      int       ht;
      int       w;
      int       minc;
      int       x;
      int       z;
      int       slot;
      int       oldslot;
      int       a;
      int       b;
      int       wc;
      int       hc;
      int       n;
      peak_type p;
      wd   = clamp_int(int'(width_reg), 1, MAXW);
      ht   = clamp_int(int'(height_reg), 1, MAXH);
      w    = clamp_int(int'(win_reg), 1, MAXWIN);
      minc = (int'(min_reg) < w * w) ? int'(min_reg) : w * w;
      n    = 0;
      if (scan_x >= wd || scan_z >= ht) restart_scan();
      x       = scan_x;
      z       = scan_z;
      slot    = z % MAXWIN;
      oldslot = (slot + MAXWIN - w) % MAXWIN;
      // vertical window sum of this column
      col_sum[x] = (z == 0) ? int'(flag) : col_sum[x] + int'(flag);
      if (z >= w) col_sum[x] -= int'(flag_hist[oldslot*MAXW + x]);
      flag_hist[slot*MAXW + x] = flag;
      // horizontal sum over the last w columns
      box_sum = (x == 0) ? col_sum[0] : box_sum + col_sum[x];
      if (x >= w) box_sum -= col_sum[x - w];
      if (x + 1 >= w && z + 1 >= w) begin
         a  = x + 1 - w;
         b  = z + 1 - w;
         wc = wd - w + 1;
         hc = ht - w + 1;
         count_rows[b % 3][a] = box_sum;
         if (b >= 1) begin
            if (a >= 1) n += judge_square(a - 1, b - 1, wc, hc, minc);
            if (a == wc - 1) n += judge_square(a, b - 1, wc, hc, minc);
         end
         if (b == hc - 1) begin
            if (a >= 1) n += judge_square(a - 1, b, wc, hc, minc);
            if (a == wc - 1) n += judge_square(a, b, wc, hc, minc);
         end
      end
      x++;
      if (x == wd) begin
         x = 0;
         z++;
      end
      if (z == ht) begin
         p.count     = '0;
         p.cx        = '0;
         p.cz        = '0;
         p.end_mark  = 1'b1;
         p.too_small = (wd < w || ht < w);
         p.last      = 1'b0;
         queue_peak(p);
         n++;
         restart_scan();
      end else begin
         scan_x = x;
         scan_z = z;
      end
      if (n > 0) pending_peaks[$].last = 1'b1;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_REGION_WIDTH: begin
            width_reg = val[10:0];
         end
         REG_REGION_HEIGHT: begin
            height_reg = val[20:0];
         end
         REG_WINDOW_SIZE: begin
            win_reg = val[8:0];
         end
         REG_MIN_COUNT: begin
            min_reg = val[16:0];
         end
         REG_ORIGIN_X: begin
            ox_reg = val;
         end
         REG_ORIGIN_Z: begin
            oz_reg = val;
         end
         default: begin
            return;
         end
      endcase
      restart_scan();
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      peak_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_peaks.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_peaks.pop_front();
            if (rsp_tdata[16:0] !== want.count)
               report_mismatch("peak_count", rsp_tdata[16:0], want.count);
            if (rsp_tdata[41:17] !== want.cx)
               report_mismatch("corner_x", rsp_tdata[41:17], want.cx);
            if (rsp_tdata[66:42] !== want.cz)
               report_mismatch("corner_z", rsp_tdata[66:42], want.cz);
            if (rsp_tuser[0] !== want.end_mark)
               report_mismatch("end_marker", rsp_tuser[0], want.end_mark);
            if (rsp_tuser[1] !== want.too_small)
               report_mismatch("area_too_small", rsp_tuser[1], want.too_small);
            if (rsp_tlast !== want.last)
               report_mismatch("last_in_run", rsp_tlast, want.last);
         end
      end
   end

   // receiver: hold off for a requested stretch, otherwise stall at random while jitter is on
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= !(jitter_on && $urandom_range(99) < 15);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // send one flag request; valid stays high into the next call unless it idles
   task automatic send_flag(bit flag);
      while (jitter_on && $urandom_range(99) < 15) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(flag);
      do @(posedge clock); while (!req_tready);
      predict_peaks(flag);
   endtask

   task automatic send_random_flags(int n, int density);
      for (int i = 0; i < n; i++) send_flag($urandom_range(99) < density);
   endtask

   // wait for the block to drain, then write all six registers
   task automatic configure(int w, int h, int win, int minc, int ox, int oz);
      logic [CSR_DATA_W-1:0] vals [6];
      vals = '{CSR_DATA_W'(w), CSR_DATA_W'(h), CSR_DATA_W'(win), CSR_DATA_W'(minc),
               CSR_DATA_W'(ox), CSR_DATA_W'(oz)};
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (2 * PIPE_STAGES) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         apply_csr(CSR_IDX_W'(i), vals[i]);
         @(negedge clock);
         csr_we <= 1'b0;
      end
   endtask

   // region narrower than the window, then window clamped from above
   task automatic test_small_region();
      configure(3, 2, 4, 1, 0, 0);
      send_flag(1); send_flag(1); send_flag(0);
      send_flag(1); send_flag(0); send_flag(1);
      configure(5, 1, 511, 1, 0, 0);
      send_random_flags(5, 50);
   endtask

   // window of one, zero minimum, ties, corner wrap and zero-clamped registers
   task automatic test_extremes();
      configure(4, 3, 1, 0, 25'h0FFFFFF, -10000000);
      send_flag(1); send_flag(1); send_flag(0); send_flag(1);
      send_flag(0); send_flag(0); send_flag(0); send_flag(1);
      send_flag(1); send_flag(1); send_flag(1); send_flag(1);
      // clamp width, height and window up to one: end marker per request, square for each set flag
      configure(0, 0, 0, 65536, 10000000, 25'h1FFFFFF);
      send_flag(1); send_flag(0); send_flag(1);
      configure(3, 3, 2, 65536, -1, 3);
      send_flag(1); send_flag(1); send_flag(1);
      send_flag(1); send_flag(1); send_flag(1);
      send_flag(1); send_flag(1); send_flag(1);
   endtask

   // starts into the widest and the tallest regions, no idling on either side
   task automatic test_full_size();
      jitter_on = 1'b0;
      configure(1024, 1, 1, 1, -10000000, 10000000);
      send_random_flags(30, 30);
      configure(2047, 2, 256, 5, 0, 0);
      send_random_flags(20, 50);
      configure(1, 1048576, 1, 1, 0, -10000000);
      send_random_flags(20, 50);
      jitter_on = 1'b1;
   endtask

   // random scans, mostly whole regions, some broken off or run twice
   task automatic test_random_scans();
      int sent;
      int wd;
      int ht;
      int w;
      int n;
      sent = 0;
      while (sent < 115) begin
         wd = $urandom_range(1, 12);
         ht = $urandom_range(1, 9);
         w  = $urandom_range(1, 5);
         configure(wd, ht, w, $urandom_range(0, w * w + 2),
                   int'($urandom_range(20000000)) - 10000000,
                   int'($urandom_range(20000000)) - 10000000);
         case ($urandom_range(9))
            0: begin
               n = $urandom_range(1, wd * ht);
            end
            1: begin
               n = 2 * wd * ht;
            end
            default: begin
               n = wd * ht;
            end
         endcase
         if (sent + n > 130) n = 130 - sent;
         send_random_flags(n, $urandom_range(10, 90));
         sent += n;
      end
   endtask

   // receiver holds off long while single-cell scans keep coming, so the block backs up
   task automatic test_backpressure();
      configure(1, 1, 1, 0, 100, 200);
      @(negedge clock);
      hold_cycles = 300;
      send_random_flags(40, 60);
   endtask

   initial begin
      width_reg  = 11'd1024;
      height_reg = 21'd1024;
      win_reg    = 9'd10;
      min_reg    = 17'd15;
      ox_reg     = '0;
      oz_reg     = '0;
      restart_scan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_small_region();
      test_extremes();
      test_random_scans();
      test_backpressure();
      test_full_size();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (4 * PIPE_STAGES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/wcpf_pkg.sv
design/wcpf_box.sv
design/wcpf_nms.sv
design/wcpf_out_fifo.sv
design/window_count_peak_finder.sv
tb/window_count_peak_finder_tb.sv
